[src/tlpt_pkg.sv]
// Package for the tensor layout planner tag block: item record, tag constants
// and the tag mixing function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tlpt_pkg;

    localparam int DIV_STAGES = 7;
    localparam int DIV_STEPS  = 4;
    localparam int MIX_STAGES = 8;
    localparam int BEAT_SHIFT = 4;
    localparam int ROW_SHIFT  = 9;

    localparam logic [63:0] TAG_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] TAG_KIND  = 64'h0000000074656e73;

    // h ^ w times 0x100000001b3, as shifts and adds
    function automatic logic [63:0] mix_word(input logic [63:0] h, input logic [63:0] w);
        logic [63:0] x;
        x = h ^ w;
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    localparam logic [63:0] TAG_START = mix_word(TAG_BASIS, TAG_KIND);

    typedef struct packed {
        logic        zero;
        logic [7:0]  layout;
        logic [24:0] nredpad;
        logic [16:0] chunks;
        logic [5:0]  beats;
        logic [27:0] num;
        logic [11:0] rem;
        logic [27:0] quot;
        logic [23:0] groups;
        logic [24:0] noutpad;
        logic [40:0] prod;
        logic [63:0] lo_p;
        logic [40:0] hi_p;
        logic [72:0] full;
        logic [63:0] h;
    } item_t;

endpackage
`default_nettype wire

[src/tlpt_div.sv]
// Pipelined restoring divider for the padded output length, four quotient bits
// per stage. Depends on tlpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_div
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic [12:0]    per,
    input  wire logic           in_vld,
    input  tlpt_pkg::item_t     in_item,
    output logic                out_vld,
    output tlpt_pkg::item_t     out_item
);

    tlpt_pkg::item_t                  st_reg  [tlpt_pkg::DIV_STAGES];
    tlpt_pkg::item_t                  st_next [tlpt_pkg::DIV_STAGES];
    logic [tlpt_pkg::DIV_STAGES-1:0]  vld_reg;

    for (genvar s = 0; s < tlpt_pkg::DIV_STAGES; s++)
    begin : g_st
        tlpt_pkg::item_t src;
        logic            src_vld;

        if (s == 0)
        begin : g_first
            assign src     = in_item;
            assign src_vld = in_vld;
        end
        else
        begin : g_rest
            assign src     = st_reg[s-1];
            assign src_vld = vld_reg[s-1];
        end

        always_comb
        begin
            tlpt_pkg::item_t w;
            logic [12:0]     r;
            w = src;
            for (int k = 0; k < tlpt_pkg::DIV_STEPS; k++)
            begin
                r = {w.rem, w.num[27]};
                w.num = {w.num[26:0], 1'b0};
                if (r >= per)
                begin
                    w.rem  = 12'(r - per);
                    w.quot = {w.quot[26:0], 1'b1};
                end
                else
                begin
                    w.rem  = r[11:0];
                    w.quot = {w.quot[26:0], 1'b0};
                end
            end
            st_next[s] = w;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[s] <= st_next[s];
        end
    end

    assign out_vld  = vld_reg[tlpt_pkg::DIV_STAGES-1];
    assign out_item = st_reg[tlpt_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

[src/tlpt_mix.sv]
// One registered tag mixing stage; the item rides along.
// Depends on tlpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_mix
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic [63:0]    word,
    input  wire logic           in_vld,
    input  tlpt_pkg::item_t     in_item,
    output logic                out_vld,
    output tlpt_pkg::item_t     out_item
);

    tlpt_pkg::item_t item_reg;
    tlpt_pkg::item_t item_next;
    logic            vld_reg;

    always_comb
    begin
        item_next   = in_item;
        item_next.h = tlpt_pkg::mix_word(in_item.h, word);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule
`default_nettype wire

[src/tensor_layout_planner_tag_top.sv]
// Top level of the tensor layout planner tag block: configuration registers,
// entry and size stages. Depends on tlpt_pkg, tlpt_div and tlpt_mix.
//
// Each request beat takes one register stage at entry, seven divider stages,
// one multiply stage and eight tag mixing stages between an accepted input
// beat and its result. A new beat is taken in every cycle but while a result
// waits at the output, when the whole pipeline holds. The divider for the
// output rounding and the chain of tag mixes set the depth.
`timescale 1ns / 1ps
`default_nettype none
module tensor_layout_planner_tag_top
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     layout_code,
    input  wire logic [23:0]    out_len,
    input  wire logic [23:0]    red_len,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [24:0]         out_len_padded,
    output logic [23:0]         group_count,
    output logic [24:0]         red_len_padded,
    output logic [15:0]         chunk_count,
    output logic [5:0]          last_chunk_beats,
    output logic [63:0]         total_bytes,
    output logic                size_overflow,
    output logic [63:0]         layout_tag
);

    logic [6:0]  channel_count_reg;
    logic [6:0]  bank_count_reg;
    logic [15:0] row_size_bytes_reg;
    logic [31:0] unit_size_bytes_reg;

    logic        en;
    logic [6:0]  nch;
    logic [6:0]  nbank;
    logic [12:0] per;

    tlpt_pkg::item_t s0_reg, s0_next;
    logic            s0_vld_reg;
    tlpt_pkg::item_t dv_item;
    logic            dv_vld;
    tlpt_pkg::item_t s8_reg, s8_next;
    logic            s8_vld_reg;

    tlpt_pkg::item_t mx_in  [tlpt_pkg::MIX_STAGES];
    tlpt_pkg::item_t mx_out [tlpt_pkg::MIX_STAGES];
    logic            mx_vin [tlpt_pkg::MIX_STAGES];
    logic            mx_vout[tlpt_pkg::MIX_STAGES];
    logic [63:0]     mx_word[tlpt_pkg::MIX_STAGES];
    tlpt_pkg::item_t fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg   <= 7'd1;
            bank_count_reg      <= 7'd1;
            row_size_bytes_reg  <= 16'd1024;
            unit_size_bytes_reg <= 32'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                2'd0:    channel_count_reg   <= cfg_data[6:0];
                2'd1:    bank_count_reg      <= cfg_data[6:0];
                2'd2:    row_size_bytes_reg  <= cfg_data[15:0];
                default: unit_size_bytes_reg <= cfg_data;
            endcase
        end
    end

    assign nch      = (channel_count_reg == 7'd0) ? 7'd1 : channel_count_reg;
    assign nbank    = (bank_count_reg == 7'd0) ? 7'd1 : bank_count_reg;
    assign per      = 13'(nch * nbank);
    assign en       = !mx_vout[tlpt_pkg::MIX_STAGES-1] || out_ready;
    assign in_ready = en;

    // entry: rounding of the reduction length, the divider numerator and the layout mix
    always_comb
    begin
        logic [25:0] csum;
        s0_next         = '0;
        s0_next.zero    = (out_len == 24'd0) || (red_len == 24'd0);
        s0_next.layout  = layout_code;
        s0_next.nredpad = (25'(red_len) + 25'd15) & ~25'd15;
        csum            = 26'(s0_next.nredpad) + 26'd511;
        s0_next.chunks  = 17'(csum >> tlpt_pkg::ROW_SHIFT);
        s0_next.beats   = 6'((26'(s0_next.nredpad) - ((26'(s0_next.chunks) - 26'd1)
                          << tlpt_pkg::ROW_SHIFT)) >> tlpt_pkg::BEAT_SHIFT);
        s0_next.num     = 28'(25'(out_len) + 25'(per) - 25'd1);
        s0_next.h       = tlpt_pkg::mix_word(tlpt_pkg::TAG_START, 64'(layout_code));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= in_valid;
            s8_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= s0_next;
            s8_reg <= s8_next;
        end
    end

    tlpt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .per      (per),
        .in_vld   (s0_vld_reg),
        .in_item  (s0_reg),
        .out_vld  (dv_vld),
        .out_item (dv_item)
    );

    always_comb
    begin
        s8_next         = dv_item;
        s8_next.groups  = dv_item.quot[23:0];
        s8_next.noutpad = 25'(dv_item.quot[23:0] * per);
        s8_next.prod    = 41'(dv_item.quot[23:0] * dv_item.chunks);
    end

    assign mx_word[0] = 64'(s8_reg.noutpad);
    assign mx_word[1] = 64'(mx_out[0].nredpad);
    assign mx_word[2] = 64'(mx_out[1].chunks);
    assign mx_word[3] = 64'(mx_out[2].groups);
    assign mx_word[4] = 64'(channel_count_reg);
    assign mx_word[5] = 64'(bank_count_reg);
    assign mx_word[6] = 64'(row_size_bytes_reg);
    assign mx_word[7] = 64'(unit_size_bytes_reg);

    for (genvar m = 0; m < tlpt_pkg::MIX_STAGES; m++)
    begin : g_mix
        if (m == 0)
        begin : g_first
            always_comb
            begin
                mx_in[m]      = s8_reg;
                mx_in[m].lo_p = 64'(s8_reg.prod[31:0] * unit_size_bytes_reg);
                mx_in[m].hi_p = 41'(s8_reg.prod[40:32] * unit_size_bytes_reg);
            end
            assign mx_vin[m] = s8_vld_reg;
        end
        else if (m == 1)
        begin : g_sum
            always_comb
            begin
                mx_in[m]      = mx_out[m-1];
                mx_in[m].full = {9'd0, mx_out[m-1].lo_p} + {mx_out[m-1].hi_p, 32'd0};
            end
            assign mx_vin[m] = mx_vout[m-1];
        end
        else
        begin : g_rest
            assign mx_in[m]  = mx_out[m-1];
            assign mx_vin[m] = mx_vout[m-1];
        end

        tlpt_mix u_mix
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .word     (mx_word[m]),
            .in_vld   (mx_vin[m]),
            .in_item  (mx_in[m]),
            .out_vld  (mx_vout[m]),
            .out_item (mx_out[m])
        );
    end

    assign fin       = mx_out[tlpt_pkg::MIX_STAGES-1];
    assign out_valid = mx_vout[tlpt_pkg::MIX_STAGES-1];

    always_comb
    begin
        if (fin.zero)
        begin
            out_len_padded   = '0;
            group_count      = '0;
            red_len_padded   = '0;
            chunk_count      = '0;
            last_chunk_beats = '0;
            total_bytes      = '0;
            size_overflow    = 1'b0;
            layout_tag       = '0;
        end
        else
        begin
            out_len_padded   = fin.noutpad;
            group_count      = fin.groups;
            red_len_padded   = fin.nredpad;
            chunk_count      = fin.chunks[15:0];
            last_chunk_beats = fin.beats;
            total_bytes      = fin.full[63:0];
            size_overflow    = |fin.full[72:64];
            layout_tag       = (fin.h == 64'd0) ? 64'd1 : fin.h;
        end
    end

    a_tag_zero_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && layout_tag == 64'd0 |-> out_len_padded == 25'd0)
        else $error("zero tag on a non-empty result");

    a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_len_padded == 25'd0 |-> total_bytes == 64'd0 && !size_overflow)
        else $error("size on an empty result");

    a_beats_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_len_padded != 25'd0
            |-> last_chunk_beats != 6'd0 && last_chunk_beats <= 6'd32)
        else $error("last chunk beats out of range");

endmodule
`default_nettype wire
